FILE: src/vnf_pkg.sv
// Shared types and constants for the vertex normal block.
// Used by vnf_walk, vnf_norm and vertex_normal_from_faces_top; depends on nothing.
package vnf_pkg;

    // Input command codes.
    localparam logic [1:0] CMD_LOAD_VERT = 2'd0;
    localparam logic [1:0] CMD_LOAD_FACE = 2'd1;
    localparam logic [1:0] CMD_QUERY     = 2'd2;

    // Result status codes.
    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_NO_DIR = 2'd1;
    localparam logic [1:0] STATUS_RANGE  = 2'd2;

    // Register indexes on the configuration port.
    localparam logic REG_VERTEX_COUNT = 1'b0;
    localparam logic REG_FACE_COUNT   = 1'b1;

    localparam int COORD_W  = 16;
    localparam int CORNER_W = 11;
    localparam int SLOT_W   = 12;
    localparam int SUM_W    = 48;
    localparam int OUT_W    = 16;

    // Accumulated face normal sum of one query.
    typedef struct packed {
        logic signed [SUM_W-1:0] x;
        logic signed [SUM_W-1:0] y;
        logic signed [SUM_W-1:0] z;
    } sum_vec_t;

    // Normalized result.
    typedef struct packed {
        logic [OUT_W-1:0] nx;
        logic [OUT_W-1:0] ny;
        logic [OUT_W-1:0] nz;
        logic [1:0]       status;
    } norm_res_t;

endpackage

FILE: src/vnf_walk.sv
// Vertex and face memories plus the face walk that sums face normals.
// Depends on vnf_pkg.
module vnf_walk import vnf_pkg::*; #(
    parameter int MAX_VERTS = 2048,
    parameter int MAX_FACES = 4096
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     wr_vert,
    input  logic                     wr_face,
    input  logic [SLOT_W-1:0]        wr_slot,
    input  logic [COORD_W-1:0]       wr_x,
    input  logic [COORD_W-1:0]       wr_y,
    input  logic [COORD_W-1:0]       wr_z,
    input  logic [CORNER_W-1:0]      wr_a,
    input  logic [CORNER_W-1:0]      wr_b,
    input  logic [CORNER_W-1:0]      wr_c,
    input  logic                     start,
    input  logic [SLOT_W-1:0]        slot,
    input  logic [12:0]              flim,
    output logic                     done,
    output sum_vec_t                 sums
);

    localparam int VA = $clog2(MAX_VERTS);
    localparam int FA = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
    localparam int FACE_W = 3 * CORNER_W;
    localparam logic [16:0] VLIMIT = 17'(MAX_VERTS);
    localparam logic [16:0] FLIMIT = 17'(MAX_FACES);

    localparam logic [2:0] W_IDLE = 3'd0;
    localparam logic [2:0] W_FACE = 3'd1;
    localparam logic [2:0] W_FCHK = 3'd2;
    localparam logic [2:0] W_V0   = 3'd3;
    localparam logic [2:0] W_V1   = 3'd4;
    localparam logic [2:0] W_V2   = 3'd5;
    localparam logic [2:0] W_MUL  = 3'd6;
    localparam logic [2:0] W_ACC  = 3'd7;

    logic [3*COORD_W-1:0] pos_mem [MAX_VERTS];
    logic [FACE_W-1:0]    face_mem [MAX_FACES];

    logic [2:0]              state_reg, state_next;
    logic [12:0]             j_reg, j_next;
    logic [FACE_W-1:0]       face_rd_reg;
    logic [3*COORD_W-1:0]    vert_rd_reg;
    logic [VA-1:0]           vaddr;
    logic [15:0]             wslot16, j16, vsel16;
    logic [CORNER_W-1:0]     c0, c1, c2, vsel;
    logic                    oob0, oob1, oob2, hit;
    logic [3*COORD_W-1:0]    p0_reg, p1_reg, p2;
    logic signed [16:0]      a_reg [3];
    logic signed [16:0]      b_reg [3];
    logic signed [33:0]      m_reg [6];
    logic signed [34:0]      dx, dy, dz;
    sum_vec_t                sum_reg;
    logic                    done_reg;

    assign wslot16 = {4'd0, wr_slot};
    assign j16     = {3'd0, j_reg};

    // Loads write the memories directly.
    always_ff @(posedge aclk) begin
        if (wr_vert && ({5'd0, wr_slot} < VLIMIT)) begin
            pos_mem[wslot16[VA-1:0]] <= {wr_z, wr_y, wr_x};
        end
        if (wr_face && ({5'd0, wr_slot} < FLIMIT)) begin
            face_mem[wslot16[FA-1:0]] <= {wr_c, wr_b, wr_a};
        end
    end

    // Registered reads of both memories.
    always_ff @(posedge aclk) begin
        face_rd_reg <= face_mem[j16[FA-1:0]];
        vert_rd_reg <= pos_mem[vaddr];
    end

    assign c0 = face_rd_reg[CORNER_W-1:0];
    assign c1 = face_rd_reg[2*CORNER_W-1:CORNER_W];
    assign c2 = face_rd_reg[3*CORNER_W-1:2*CORNER_W];
    assign oob0 = ({6'd0, c0} >= VLIMIT);
    assign oob1 = ({6'd0, c1} >= VLIMIT);
    assign oob2 = ({6'd0, c2} >= VLIMIT);
    assign hit  = ({1'b0, c0} == slot) || ({1'b0, c1} == slot) || ({1'b0, c2} == slot);

    // Vertex read address follows the corner being fetched.
    always_comb begin
        case (state_reg)
            W_V0:    vsel = c1;
            W_V1:    vsel = c2;
            default: vsel = c0;
        endcase
    end
    assign vsel16 = {5'd0, vsel};
    assign vaddr  = vsel16[VA-1:0];

    assign p2 = oob2 ? '0 : vert_rd_reg;

    // Walk sequencer.
    always_comb begin
        state_next = state_reg;
        j_next     = j_reg;
        unique case (state_reg)
            W_IDLE: begin
                if (start) begin
                    j_next     = '0;
                    state_next = (flim == 13'd0) ? W_IDLE : W_FACE;
                end
            end
            W_FACE: state_next = W_FCHK;
            W_FCHK: begin
                if (hit) begin
                    state_next = W_V0;
                end else begin
                    j_next     = j_reg + 13'd1;
                    state_next = (j_next == flim) ? W_IDLE : W_FACE;
                end
            end
            W_V0:  state_next = W_V1;
            W_V1:  state_next = W_V2;
            W_V2:  state_next = W_MUL;
            W_MUL: state_next = W_ACC;
            W_ACC: begin
                j_next     = j_reg + 13'd1;
                state_next = (j_next == flim) ? W_IDLE : W_FACE;
            end
            default: state_next = W_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= W_IDLE;
            j_reg     <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            j_reg     <= j_next;
            done_reg  <= (state_reg != W_IDLE || start) && (state_next == W_IDLE);
        end
    end

    // Corner positions, edge vectors and cross product terms.
    always_ff @(posedge aclk) begin
        if (state_reg == W_V0) begin
            p0_reg <= oob0 ? '0 : vert_rd_reg;
        end
        if (state_reg == W_V1) begin
            p1_reg <= oob1 ? '0 : vert_rd_reg;
        end
        if (state_reg == W_V2) begin
            for (int k = 0; k < 3; k++) begin
                a_reg[k] <= 17'(signed'(p0_reg[k*COORD_W +: COORD_W]))
                          - 17'(signed'(p2[k*COORD_W +: COORD_W]));
                b_reg[k] <= 17'(signed'(p2[k*COORD_W +: COORD_W]))
                          - 17'(signed'(p1_reg[k*COORD_W +: COORD_W]));
            end
        end
        if (state_reg == W_MUL) begin
            m_reg[0] <= a_reg[1] * b_reg[2];
            m_reg[1] <= a_reg[2] * b_reg[1];
            m_reg[2] <= a_reg[2] * b_reg[0];
            m_reg[3] <= a_reg[0] * b_reg[2];
            m_reg[4] <= a_reg[0] * b_reg[1];
            m_reg[5] <= a_reg[1] * b_reg[0];
        end
    end

    assign dx = {m_reg[0][33], m_reg[0]} - {m_reg[1][33], m_reg[1]};
    assign dy = {m_reg[2][33], m_reg[2]} - {m_reg[3][33], m_reg[3]};
    assign dz = {m_reg[4][33], m_reg[4]} - {m_reg[5][33], m_reg[5]};

    // Running sum, cleared when a query starts.
    always_ff @(posedge aclk) begin
        if (state_reg == W_IDLE && start) begin
            sum_reg <= '0;
        end else if (state_reg == W_ACC) begin
            sum_reg.x <= sum_reg.x + {{(SUM_W-35){dx[34]}}, dx};
            sum_reg.y <= sum_reg.y + {{(SUM_W-35){dy[34]}}, dy};
            sum_reg.z <= sum_reg.z + {{(SUM_W-35){dz[34]}}, dz};
        end
    end

    assign done = done_reg;
    assign sums = sum_reg;

endmodule

FILE: src/vnf_norm.sv
// Normalizer: prescale, sum of squares, bit-serial square root and divide.
// Depends on vnf_pkg.
module vnf_norm import vnf_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      start,
    input  sum_vec_t  sums,
    output logic      done,
    output norm_res_t res
);

    localparam logic [2:0] N_IDLE  = 3'd0;
    localparam logic [2:0] N_CHK   = 3'd1;
    localparam logic [2:0] N_SHIFT = 3'd2;
    localparam logic [2:0] N_SQ    = 3'd3;
    localparam logic [2:0] N_SQRT  = 3'd4;
    localparam logic [2:0] N_DLOAD = 3'd5;
    localparam logic [2:0] N_DIV   = 3'd6;

    logic [2:0]        state_reg;
    logic [SUM_W-1:0]  mag_reg [3];
    logic [2:0]        neg_reg;
    logic [1:0]        cnt_reg;
    logic [3:0]        bit_cnt_reg;
    logic [59:0]       prod_reg;
    logic [63:0]       ssq_reg, rem_reg, res_reg, sbit_reg, trial;
    logic [47:0]       num_reg, dsh_reg;
    logic [14:0]       q_reg, q_next;
    logic [29:0]       msel;
    logic [OUT_W-1:0]  qs;
    logic              done_reg;
    norm_res_t         res_reg_o;

    assign msel  = mag_reg[cnt_reg][29:0];
    assign trial = res_reg + sbit_reg;
    assign q_next = {q_reg[13:0], (num_reg >= dsh_reg)};
    assign qs = neg_reg[cnt_reg] ? (OUT_W'(0) - {1'b0, q_next}) : {1'b0, q_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= N_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                // Take magnitudes and signs.
                N_IDLE: begin
                    if (start) begin
                        neg_reg    <= {sums.z[SUM_W-1], sums.y[SUM_W-1], sums.x[SUM_W-1]};
                        mag_reg[0] <= sums.x[SUM_W-1] ? -sums.x : sums.x;
                        mag_reg[1] <= sums.y[SUM_W-1] ? -sums.y : sums.y;
                        mag_reg[2] <= sums.z[SUM_W-1] ? -sums.z : sums.z;
                        state_reg  <= N_CHK;
                    end
                end
                // A zero sum has no direction.
                N_CHK: begin
                    if (mag_reg[0] == '0 && mag_reg[1] == '0 && mag_reg[2] == '0) begin
                        res_reg_o <= '{nx: '0, ny: '0, nz: '0, status: STATUS_NO_DIR};
                        done_reg  <= 1'b1;
                        state_reg <= N_IDLE;
                    end else begin
                        state_reg <= N_SHIFT;
                    end
                end
                // Scale down one bit a cycle until all fit in 30 bits.
                N_SHIFT: begin
                    if ((|mag_reg[0][SUM_W-1:30]) || (|mag_reg[1][SUM_W-1:30])
                        || (|mag_reg[2][SUM_W-1:30])) begin
                        for (int k = 0; k < 3; k++) begin
                            mag_reg[k] <= mag_reg[k] >> 1;
                        end
                    end else begin
                        cnt_reg   <= 2'd0;
                        ssq_reg   <= '0;
                        state_reg <= N_SQ;
                    end
                end
                // One square a cycle, each summed in the following cycle.
                N_SQ: begin
                    if (cnt_reg != 2'd3) begin
                        prod_reg <= msel * msel;
                    end
                    if (cnt_reg != 2'd0) begin
                        ssq_reg <= ssq_reg + {4'd0, prod_reg};
                    end
                    if (cnt_reg == 2'd3) begin
                        rem_reg   <= ssq_reg + {4'd0, prod_reg};
                        res_reg   <= '0;
                        sbit_reg  <= 64'h4000_0000_0000_0000;
                        state_reg <= N_SQRT;
                    end
                    cnt_reg <= cnt_reg + 2'd1;
                end
                // Restoring square root, one result bit a cycle.
                N_SQRT: begin
                    if (rem_reg >= trial) begin
                        rem_reg <= rem_reg - trial;
                        res_reg <= (res_reg >> 1) + sbit_reg;
                    end else begin
                        res_reg <= res_reg >> 1;
                    end
                    sbit_reg <= sbit_reg >> 2;
                    if (sbit_reg[0]) begin
                        cnt_reg   <= 2'd0;
                        state_reg <= N_DLOAD;
                    end
                end
                // Set up the rounded quotient mag * 2^15 + r over 2r.
                N_DLOAD: begin
                    num_reg     <= {mag_reg[cnt_reg][32:0], 15'd0} + {16'd0, res_reg[31:0]};
                    dsh_reg     <= {res_reg[32:0], 15'd0};
                    q_reg       <= '0;
                    bit_cnt_reg <= 4'd14;
                    state_reg   <= N_DIV;
                end
                // Restoring division, one quotient bit a cycle.
                N_DIV: begin
                    if (num_reg >= dsh_reg) begin
                        num_reg <= num_reg - dsh_reg;
                    end
                    dsh_reg     <= dsh_reg >> 1;
                    q_reg       <= q_next;
                    bit_cnt_reg <= bit_cnt_reg - 4'd1;
                    if (bit_cnt_reg == 4'd0) begin
                        case (cnt_reg)
                            2'd0:    res_reg_o.nx <= qs;
                            2'd1:    res_reg_o.ny <= qs;
                            default: res_reg_o.nz <= qs;
                        endcase
                        if (cnt_reg == 2'd2) begin
                            res_reg_o.status <= STATUS_OK;
                            done_reg  <= 1'b1;
                            state_reg <= N_IDLE;
                        end else begin
                            cnt_reg   <= cnt_reg + 2'd1;
                            state_reg <= N_DLOAD;
                        end
                    end
                end
                default: state_reg <= N_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign res  = res_reg_o;

endmodule

FILE: src/vertex_normal_from_faces_top.sv
// Top level: configuration registers, stream handshakes and query control.
// Depends on vnf_pkg, vnf_walk and vnf_norm.
//
// Usage: write vertex_count (address 0) and face_count (address 4) over the
// APB-style port while the block is idle. Each request on the s_ stream
// carries a command in s_tuser: load vertex and load face requests write the
// memories and give no result. A query request gives one result on the m_
// stream with the status in m_tuser.
// Flow: a query whose slot is at or beyond the vertex count gets a
// STATUS_RANGE result without a walk. Otherwise the face walk reads each face
// (W_FACE, W_FCHK) and goes on through W_V0, W_V1, W_V2, W_MUL and W_ACC for
// each face that uses the vertex; the normalizer then prescales, sums the
// squares, takes the square root and divides. Queries are handled one at a
// time; the walk's face memory port sets the bulk of the latency.
// Reset clears the counts and control; memory contents stay undefined until
// loaded. While a result waits on a stalled m_ side, no new request is taken.
module vertex_normal_from_faces_top import vnf_pkg::*; #(
    parameter int MAX_VERTS = 2048,
    parameter int MAX_FACES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Request stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: slot[11:0], coord_x[27:12], coord_y[43:28], coord_z[59:44],
    //          corner_a[70:60], corner_b[81:71], corner_c[92:82], zero[95:93]
    input  logic [95:0] s_tdata,
    // s_tuser: cmd[1:0]
    input  logic [1:0]  s_tuser,
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: vertex_id[10:0], normal_x[26:11], normal_y[42:27],
    //          normal_z[58:43], zero[63:59]
    output logic [63:0] m_tdata,
    // m_tuser: status[1:0]
    output logic [1:0]  m_tuser
);

    localparam logic [16:0] VLIMIT = 17'(MAX_VERTS);
    localparam logic [16:0] FLIMIT = 17'(MAX_FACES);

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_WALK = 2'd1;
    localparam logic [1:0] T_NORM = 2'd2;

    logic [11:0]          vcount_reg;
    logic [12:0]          fcount_reg;
    logic [1:0]           state_reg;
    logic                 cfg_wr, accept, out_free;
    logic [1:0]           cmd;
    logic [SLOT_W-1:0]    slot;
    logic [SLOT_W-1:0]    qslot_reg;
    logic [16:0]          vlim;
    logic [12:0]          flim;
    logic                 walk_start, walk_done, norm_done, in_range;
    sum_vec_t             sums;
    norm_res_t            nres;
    logic                 m_valid_reg;
    logic [63:0]          m_data_reg;
    logic [1:0]           m_user_reg;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= '0;
            fcount_reg <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_VERTEX_COUNT: vcount_reg <= pwdata[11:0];
                REG_FACE_COUNT:   fcount_reg <= pwdata[12:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_VERTEX_COUNT: prdata = {20'd0, vcount_reg};
            REG_FACE_COUNT:   prdata = {19'd0, fcount_reg};
            default:          prdata = '0;
        endcase
    end

    // Counts above the store size act as the store size.
    assign vlim = ({5'd0, vcount_reg} < VLIMIT) ? {5'd0, vcount_reg} : VLIMIT;
    assign flim = ({4'd0, fcount_reg} < FLIMIT) ? fcount_reg : FLIMIT[12:0];

    // Request handshake.
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == T_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign cmd      = s_tuser;
    assign slot     = s_tdata[11:0];
    assign in_range = ({5'd0, slot} < vlim);
    assign walk_start = accept && (cmd == CMD_QUERY) && in_range;

    vnf_walk #(
        .MAX_VERTS (MAX_VERTS),
        .MAX_FACES (MAX_FACES)
    ) u_walk (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_vert (accept && (cmd == CMD_LOAD_VERT)),
        .wr_face (accept && (cmd == CMD_LOAD_FACE)),
        .wr_slot (slot),
        .wr_x    (s_tdata[27:12]),
        .wr_y    (s_tdata[43:28]),
        .wr_z    (s_tdata[59:44]),
        .wr_a    (s_tdata[70:60]),
        .wr_b    (s_tdata[81:71]),
        .wr_c    (s_tdata[92:82]),
        .start   (walk_start),
        .slot    (qslot_reg),
        .flim    (flim),
        .done    (walk_done),
        .sums    (sums)
    );

    vnf_norm u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (walk_done),
        .sums    (sums),
        .done    (norm_done),
        .res     (nres)
    );

    // Query sequencing.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= T_IDLE;
        end else begin
            unique case (state_reg)
                T_IDLE: if (walk_start) state_reg <= T_WALK;
                T_WALK: if (walk_done) state_reg <= T_NORM;
                T_NORM: if (norm_done) state_reg <= T_IDLE;
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    // The queried slot is held for the whole walk.
    always_ff @(posedge aclk) begin
        if (walk_start) begin
            qslot_reg <= slot;
        end
    end

    // Output register; it is always empty when a query finishes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (accept && (cmd == CMD_QUERY) && !in_range) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= {5'd0, 48'd0, slot[10:0]};
                m_user_reg  <= STATUS_RANGE;
            end else if (state_reg == T_NORM && norm_done) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= {5'd0, nres.nz, nres.ny, nres.nx, qslot_reg[10:0]};
                m_user_reg  <= nres.status;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
